// File: hdl/xs128_pkg.sv
// Shared types and constants for the xorshift128 generator.
// No dependencies.
package xs128_pkg;

  localparam int STATE_BITS = 128;
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = STATE_BITS / WORD_BITS;
  localparam int SLOT_BITS  = $clog2(WORD_COUNT);
  localparam int SHIFT_BITS = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [SHIFT_BITS-1:0] shamt_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;

  // Request kinds on the input channel.
  typedef enum logic {
    REQ_STEP = 1'b0,
    REQ_LOAD = 1'b1
  } req_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SHIFT_A        = 2'd0,
    REG_SHIFT_B        = 2'd1,
    REG_SHIFT_C        = 2'd2,
    REG_UPDATE_PATTERN = 2'd3
  } reg_idx_t;

  // Update pattern codes.
  typedef enum logic {
    PAT_MARSAGLIA = 1'b0,
    PAT_ALT       = 1'b1
  } pattern_t;

  // Configuration as seen by the mix logic.
  typedef struct packed {
    shamt_t   shift_a;
    shamt_t   shift_b;
    shamt_t   shift_c;
    pattern_t update_pattern;
  } cfg_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic shift_en;
    logic load_en;
  } cell_ctl_t;

  localparam shamt_t RST_SHIFT_A = SHIFT_BITS'(11);
  localparam shamt_t RST_SHIFT_B = SHIFT_BITS'(8);
  localparam shamt_t RST_SHIFT_C = SHIFT_BITS'(19);

endpackage

// File: hdl/xs128_cell.sv
// One state word of the generator chain: shifts in its neighbor's word
// or takes a seed word. Depends on xs128_pkg.
module xs128_cell (
  input  logic              clk,
  input  logic              rst,
  input  xs128_pkg::cell_ctl_t ctl,
  input  xs128_pkg::word_t  shift_in,
  input  xs128_pkg::word_t  load_data,
  output xs128_pkg::word_t  word
);
  import xs128_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (ctl.load_en) begin
      word <= load_data;
    end else if (ctl.shift_en) begin
      word <= shift_in;
    end
  end

endmodule

// File: hdl/xs128_mix.sv
// Next-w computation for both update patterns.
// Depends on xs128_pkg.
module xs128_mix (
  input  xs128_pkg::cfg_t  cfg,
  input  xs128_pkg::word_t word_x,
  input  xs128_pkg::word_t word_w,
  output xs128_pkg::word_t new_w
);
  import xs128_pkg::*;

  word_t t0;
  word_t t1;

  always_comb begin
    t0    = '0;
    t1    = '0;
    new_w = '0;
    case (cfg.update_pattern)
      PAT_MARSAGLIA: begin
        t0    = word_x ^ (word_x << cfg.shift_a);
        t1    = t0;
        new_w = word_w ^ (word_w >> cfg.shift_c) ^ t0 ^ (t0 >> cfg.shift_b);
      end
      PAT_ALT: begin
        t0    = word_x ^ (word_x << cfg.shift_b);
        t1    = t0 ^ (t0 >> cfg.shift_c);
        new_w = word_w ^ (word_w << cfg.shift_a) ^ t1;
      end
      default: begin
        new_w = '0;
      end
    endcase
  end

endmodule

// File: hdl/xorshift128_generator_step.sv
// Top level of the xorshift128 generator: config registers, cell chain,
// output register. Depends on xs128_pkg, xs128_cell, xs128_mix.
//
// Usage:
//  - Input channel (in_valid / in_stall): each word is either a step
//    request (req_type = REQ_STEP) or a seed load (REQ_LOAD) that writes
//    one state word: seed_index 0 w, 1 z, 2 y, 3 x. Loads give no result.
//  - Output channel (out_valid / out_stall): one random_word per step,
//    the new w.
//  - Config channel (cfg_valid / cfg_ready): cfg_ready is always high;
//    cfg_index selects shift_a, shift_b, shift_c or update_pattern, the
//    low bits of cfg_data are written. Write only while idle.
//  - Output: a step's new w is written to the output register at the
//    same edge that accepts the step. Throughput: one word per cycle
//    while the input is not stalled. The chain of four word cells shifts
//    and the mix logic computes new w combinationally from registered x
//    and w, so steps and loads go back to back. Stall: the output
//    register holds its word while out_stall is high; the input stalls
//    only when that register is full and stalled. Reset: all state words
//    clear to zero (a zero state stays zero), shifts return to 11/8/19, pattern to the Marsaglia form.
module xorshift128_generator_step (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  xs128_pkg::req_t       req_type,
  input  xs128_pkg::slot_t      seed_index,
  input  xs128_pkg::word_t      seed_word,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output xs128_pkg::word_t      random_word,
  // config channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  xs128_pkg::reg_idx_t   cfg_index,
  input  xs128_pkg::word_t      cfg_data
);
  import xs128_pkg::*;

  cfg_t      cfg;
  word_t     cells [WORD_COUNT];
  cell_ctl_t ctl   [WORD_COUNT];
  word_t     new_w;
  logic      in_take;
  logic      step_take;
  logic      load_take;
  logic      out_valid_next;

  // Config registers; always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shift_a        <= RST_SHIFT_A;
      cfg.shift_b        <= RST_SHIFT_B;
      cfg.shift_c        <= RST_SHIFT_C;
      cfg.update_pattern <= PAT_MARSAGLIA;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SHIFT_A:        cfg.shift_a        <= cfg_data[SHIFT_BITS-1:0];
        REG_SHIFT_B:        cfg.shift_b        <= cfg_data[SHIFT_BITS-1:0];
        REG_SHIFT_C:        cfg.shift_c        <= cfg_data[SHIFT_BITS-1:0];
        REG_UPDATE_PATTERN: cfg.update_pattern <= pattern_t'(cfg_data[0]);
        default: begin
        end
      endcase
    end
  end

  // Input handshake: blocked only by a full, stalled output register.
  assign in_stall  = out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign step_take = in_take && (req_type == REQ_STEP);
  assign load_take = in_take && (req_type == REQ_LOAD);

  // New w from the current x (last cell) and w (first cell).
  xs128_mix u_mix (
    .cfg    (cfg),
    .word_x (cells[WORD_COUNT-1]),
    .word_w (cells[0]),
    .new_w  (new_w)
  );

  // Cell 0 is w, the last cell is x; each step moves words toward x.
  for (genvar i = 0; i < WORD_COUNT; i++) begin : g_cell
    assign ctl[i].shift_en = step_take;
    assign ctl[i].load_en  = load_take && (seed_index == SLOT_BITS'(i));

    if (i == 0) begin : g_head
      xs128_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl[i]),
        .shift_in  (new_w),
        .load_data (seed_word),
        .word      (cells[i])
      );
    end else begin : g_body
      xs128_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl[i]),
        .shift_in  (cells[i-1]),
        .load_data (seed_word),
        .word      (cells[i])
      );
    end
  end

  // Output register.
  assign out_valid_next = step_take || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_take) begin
      random_word <= new_w;
    end
  end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for xorshift128_generator_step: directed table, then
// random load/step traffic over several shift/pattern settings and idle mixes.
// Depends on xs128_pkg and the xorshift128_generator_step RTL.
module testbench;
  import xs128_pkg::*;

  // seed word slots as seen on seed_index
  localparam slot_t SLOT_W = 2'd0;
  localparam slot_t SLOT_Z = 2'd1;
  localparam slot_t SLOT_Y = 2'd2;
  localparam slot_t SLOT_X = 2'd3;

  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 195;
  localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES    = 4;     // result is registered; this adds margin

  // ---------------------------------------------------------------------------
  // clock, reset, DUT ports (all driven to known values from time zero)
  // ---------------------------------------------------------------------------
  logic   clk        = 1'b0;
  logic   rst        = 1'b1;
  logic   in_valid   = 1'b0;
  logic   in_stall;
  req_t   req_type   = REQ_STEP;
  slot_t  seed_index = SLOT_W;
  word_t  seed_word  = '0;
  logic   out_valid;
  logic   out_stall  = 1'b0;
  word_t  random_word;
  logic   cfg_valid  = 1'b0;
  logic   cfg_ready;
  reg_idx_t cfg_index = REG_SHIFT_A;
  word_t  cfg_data   = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  xorshift128_generator_step u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .seed_index  (seed_index),
    .seed_word   (seed_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_word (random_word),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // predictor: its own copy of the four state words and the registers
  // ---------------------------------------------------------------------------
  word_t    gen_x = '0, gen_y = '0, gen_z = '0, gen_w = '0;
  shamt_t   sh_a  = RST_SHIFT_A;
  shamt_t   sh_b  = RST_SHIFT_B;
  shamt_t   sh_c  = RST_SHIFT_C;
  pattern_t pat   = PAT_MARSAGLIA;

  word_t due_words [$];   // random words still owed by the DUT, oldest first

  // bookkeeping
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int words_in      = 0;
  int loads_in      = 0;
  int words_out     = 0;
  int reg_writes    = 0;
  int quiet_cycles  = 0;

  // new w from the current x and w; shift by zero just cancels the term
  function automatic word_t next_w(input word_t x, input word_t w);
    word_t t;
    if (pat == PAT_MARSAGLIA) begin
      t = x ^ (x << sh_a);
      return w ^ (w >> sh_c) ^ t ^ (t >> sh_b);
    end
    t = x ^ (x << sh_b);
    t = t ^ (t >> sh_c);
    return w ^ (w << sh_a) ^ t;
  endfunction

  task automatic report(input string what, input word_t want, input word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: %s, expected %08h got %08h", what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // input side: optional gap, then hold the word until accepted.
  // valid stays high between back-to-back words (no low/high in one step).
  // ---------------------------------------------------------------------------
  task automatic offer_word(input req_t kind, input slot_t idx, input word_t data,
                            input bit typed, input word_t typed_w);
    word_t nw;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    seed_index <= idx;
    seed_word  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge: advance the predictor
    words_in++;
    if (kind == REQ_LOAD) begin
      loads_in++;
      case (idx)
        SLOT_W:  gen_w = data;
        SLOT_Z:  gen_z = data;
        SLOT_Y:  gen_y = data;
        default: gen_x = data;
      endcase
    end else begin
      nw    = next_w(gen_x, gen_w);
      gen_x = gen_y;
      gen_y = gen_z;
      gen_z = gen_w;
      gen_w = nw;
      due_words.push_back(typed ? typed_w : nw);
    end
  endtask

  // ---------------------------------------------------------------------------
  // config side: cfg_valid stays up across a batch, dropped once at the end
  // ---------------------------------------------------------------------------
  task automatic write_reg(input reg_idx_t idx, input word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    case (idx)
      REG_SHIFT_A: sh_a = data[SHIFT_BITS-1:0];
      REG_SHIFT_B: sh_b = data[SHIFT_BITS-1:0];
      REG_SHIFT_C: sh_c = data[SHIFT_BITS-1:0];
      default:     pat  = pattern_t'(data[0]);
    endcase
  endtask

  // junk in the upper bits of cfg_data must be ignored
  task automatic load_settings(input shamt_t a, input shamt_t b, input shamt_t c,
                               input pattern_t p);
    write_reg(REG_SHIFT_A, ($urandom & 32'hFFFF_FFE0) | 32'(a));
    write_reg(REG_SHIFT_B, ($urandom & 32'hFFFF_FFE0) | 32'(b));
    write_reg(REG_SHIFT_C, ($urandom & 32'hFFFF_FFE0) | 32'(c));
    write_reg(REG_UPDATE_PATTERN, ($urandom & 32'hFFFF_FFFE) | 32'(p));
    cfg_valid <= 1'b0;
  endtask

  // idle the input, wait for all owed words, then let the last load settle
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output side: check accepted words, drive out_stall (random or hold-off)
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      words_out++;
      if (due_words.size() == 0)
        report("random word with nothing pending", '0, random_word);
      else if (due_words[0] !== random_word)
        report("random_word", due_words.pop_front(), random_word);
      else
        void'(due_words.pop_front());
    end
    // a hold-off request is served here and counted down locally
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog: any handshake on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("[xorshift128_generator_step] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed table, run with the reset settings
  // ---------------------------------------------------------------------------
  typedef struct packed {
    req_t  kind;
    slot_t idx;
    word_t data;
    logic  typed;   // want holds a hand-written expectation
    word_t want;
  } dir_row_t;

  dir_row_t dir_rows [23] = '{
    // zero state stays zero; seed fields ignored on a step
    '{REQ_STEP, SLOT_X, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{REQ_STEP, SLOT_W, 32'h0000_0000, 1'b1, 32'h0000_0000},
    // x = 1, rest zero: t = 0x801, w' = t ^ (t >> 8) = 0x809
    '{REQ_LOAD, SLOT_X, 32'h0000_0001, 1'b0, 32'h0},
    '{REQ_STEP, SLOT_W, 32'h0000_0000, 1'b1, 32'h0000_0809},
    '{REQ_STEP, SLOT_Y, 32'hA5A5_A5A5, 1'b0, 32'h0},
    // extremes in every slot
    '{REQ_LOAD, SLOT_W, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{REQ_LOAD, SLOT_Z, 32'h0000_0000, 1'b0, 32'h0},
    '{REQ_LOAD, SLOT_Y, 32'h8000_0000, 1'b0, 32'h0},
    '{REQ_LOAD, SLOT_X, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{REQ_STEP, SLOT_Z, 32'h5A5A_5A5A, 1'b0, 32'h0},
    '{REQ_STEP, SLOT_X, 32'h0000_0000, 1'b0, 32'h0},
    '{REQ_STEP, SLOT_W, 32'hFFFF_FFFF, 1'b0, 32'h0},
    // reseed to all zero: back to a dead state
    '{REQ_LOAD, SLOT_W, 32'h0000_0000, 1'b0, 32'h0},
    '{REQ_LOAD, SLOT_Z, 32'h0000_0000, 1'b0, 32'h0},
    '{REQ_LOAD, SLOT_Y, 32'h0000_0000, 1'b0, 32'h0},
    '{REQ_LOAD, SLOT_X, 32'h0000_0000, 1'b0, 32'h0},
    '{REQ_STEP, SLOT_Y, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    // mixed seed, then a run of steps
    '{REQ_LOAD, SLOT_Y, 32'h1357_9BDF, 1'b0, 32'h0},
    '{REQ_LOAD, SLOT_Z, 32'h2468_ACE0, 1'b0, 32'h0},
    '{REQ_STEP, SLOT_W, 32'h0000_0000, 1'b0, 32'h0},
    '{REQ_STEP, SLOT_Z, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{REQ_STEP, SLOT_Y, 32'h0000_0001, 1'b0, 32'h0},
    '{REQ_STEP, SLOT_X, 32'hFFFF_FFFE, 1'b0, 32'h0}
  };

  // per-phase settings; later phases pick theirs at random
  shamt_t   set_a [6] = '{5'd1,  5'd31, 5'd0, 5'd0,  5'd13, 5'd11};
  shamt_t   set_b [6] = '{5'd1,  5'd31, 5'd0, 5'd31, 5'd17, 5'd8};
  shamt_t   set_c [6] = '{5'd1,  5'd31, 5'd0, 5'd1,  5'd5,  5'd19};
  pattern_t set_p [6] = '{PAT_MARSAGLIA, PAT_ALT, PAT_MARSAGLIA,
                          PAT_ALT, PAT_ALT, PAT_MARSAGLIA};

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    req_t  kind;
    slot_t idx;
    word_t data;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: sender idles 36%, receiver 86%
    send_idle_pct = 36;
    recv_idle_pct = 86;
    foreach (dir_rows[i])
      offer_word(dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].data,
                 dir_rows[i].typed, dir_rows[i].want);
    drain_pipe();

    for (int ph = 0; ph < PHASES; ph++) begin
      // idle mix: sender light / receiver heavy, then swapped, then none
      if (ph < 3) begin
        send_idle_pct = 36;
        recv_idle_pct = 86;
      end else if (ph < 6) begin
        send_idle_pct = 86;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (ph < 6)
        load_settings(set_a[ph], set_b[ph], set_c[ph], set_p[ph]);
      else
        load_settings(shamt_t'($urandom_range(31)), shamt_t'($urandom_range(31)),
                      shamt_t'($urandom_range(31)), pattern_t'($urandom_range(1)));

      // long receiver hold-off while the sender keeps offering words
      if (ph % 3 == 1) hold_requests++;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = ($urandom_range(99) < 25) ? REQ_LOAD : REQ_STEP;
        idx  = slot_t'($urandom_range(3));
        case ($urandom_range(7))
          0:       data = '0;
          1:       data = '1;
          2:       data = word_t'(1) << $urandom_range(31);
          3:       data = ~(word_t'(1) << $urandom_range(31));
          default: data = $urandom;
        endcase
        offer_word(kind, idx, data, 1'b0, '0);
      end
      drain_pipe();
    end

    repeat (8) @(posedge clk);
    if (due_words.size() != 0) begin
      mismatches += due_words.size();
      $display("%0d expected random words never arrived", due_words.size());
    end

    $display("run covered %0d input words (%0d seed loads), %0d random words checked,",
             words_in, loads_in, words_out);
    $display("%0d register writes over %0d settings, %0d mismatches",
             reg_writes, PHASES + 1, mismatches);
    if (mismatches == 0) begin
      $display("[xorshift128_generator_step] OK");
    end else begin
      $display("[xorshift128_generator_step] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/xs128_pkg.sv
hdl/xs128_cell.sv
hdl/xs128_mix.sv
hdl/xorshift128_generator_step.sv
tb/testbench.sv
